[hw/rtl/ksc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ksc_pkg;

	localparam int NUM_KEY_REGS = 5;
	localparam int ALPHA_SIZE   = 26;
	localparam int LETTER_W     = 5;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 5;
	localparam int CNT_W        = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LETTER_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd5;

	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	localparam logic [7:0] SPACE_CODE   = 8'd6;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	typedef logic [NUM_KEY_REGS-1:0][LETTER_W-1:0] key_set_t;

	// key summary derived from the key registers
	typedef struct packed {
		logic     valid;
		key_set_t letter;
		key_set_t thresh;
	} key_info_t;

endpackage

`default_nettype wire

[hw/rtl/ksc_keymap.sv]
`timescale 1ns / 1ps
`default_nettype none

module ksc_keymap #(
	parameter int KEY_LENGTH = 5
) (
	input  wire logic               clk,
	input  wire ksc_pkg::key_set_t  key_letter,
	output ksc_pkg::key_info_t      key_info
);
	import ksc_pkg::*;

	localparam int KEY_LEN_USED = (KEY_LENGTH > NUM_KEY_REGS) ? NUM_KEY_REGS : KEY_LENGTH;

	key_info_t info_d;
	key_info_t info_q;
	logic [CNT_W-1:0] rank;

	always_comb begin
		info_d = '0;
		info_d.valid = 1'b1;
		rank = '0;
		for (int j = 0; j < KEY_LEN_USED; j++) begin
			rank = '0;
			if (key_letter[j] >= LETTER_W'(ALPHA_SIZE))
				info_d.valid = 1'b0;
			for (int i = 0; i < KEY_LEN_USED; i++) begin
				if (i != j) begin
					if (key_letter[i] == key_letter[j])
						info_d.valid = 1'b0;
					if (key_letter[i] < key_letter[j])
						rank = rank + CNT_W'(1);
				end
			end
			info_d.letter[j] = key_letter[j];
			// unused letters below this key, when keys are distinct
			info_d.thresh[j] = key_letter[j] - LETTER_W'(rank);
		end
	end

	always_ff @(posedge clk) begin
		info_q <= info_d;
	end

	assign key_info = info_q;

endmodule

`default_nettype wire

[hw/rtl/keyword_substitution_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none

// keyword substitution cipher, one byte per clock
//
// request channel: in_byte is taken at a rising edge with start high and busy
// low. busy is held low, so a new byte may follow in every cycle.
// result channel: out_byte and key_error appear for one cycle with done high,
// registered through s1 decode, s2 key compares and s3 final add and select.
// throughput is one byte per cycle; the receiver cannot stall, so there is no
// back pressure anywhere.
// configuration: cfg_we writes cfg_data into register cfg_index at the edge;
// indexes 0..4 are the key letters, 5 is the direction, higher ones are
// ignored. write only while no request is in flight. the key summary (validity,
// per-key letter and threshold) is registered from the key registers, read by s2 and s3.
// reset: arst_n clears the valid bits and loads the key a,b,c,d,e and encrypt.
// a key with repeated letters or a letter above z raises key_error and every
// byte passes through untouched.
module keyword_substitution_cipher #(
	parameter int KEY_LENGTH = 5
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output      logic                              busy,
	input  wire logic [7:0]                        in_byte,
	output      logic                              done,
	output      logic [7:0]                        out_byte,
	output      logic                              key_error,
	input  wire logic                              cfg_we,
	input  wire logic [ksc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ksc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ksc_pkg::*;

	localparam int KEY_LEN_USED = (KEY_LENGTH > NUM_KEY_REGS) ? NUM_KEY_REGS : KEY_LENGTH;

	// configuration registers
	key_set_t  key_q;
	logic      dir_q;
	key_info_t ki;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_KEY_REGS; j++)
				key_q[j] <= LETTER_W'(j);
			dir_q <= DIR_ENCRYPT;
		end else if (cfg_we) begin
			for (int j = 0; j < NUM_KEY_REGS; j++)
				if (cfg_index == REG_KEY_LETTER_0 + CFG_IDX_W'(j))
					key_q[j] <= cfg_data[LETTER_W-1:0];
			if (cfg_index == REG_DIRECTION)
				dir_q <= cfg_data[0];
		end
	end

	ksc_keymap #(
		.KEY_LENGTH (KEY_LENGTH)
	) u_keymap (
		.clk        (clk),
		.key_letter (key_q),
		.key_info   (ki)
	);

	assign busy = 1'b0;

	// stage 1: capture and decode the byte
	logic                v_s1;
	logic [7:0]          byte_s1;
	logic [LETTER_W-1:0] p_s1;
	logic                letter_s1;
	logic                space_s1;
	logic                dir_s1;

	logic                is_upper;
	logic                is_lower;

	always_comb begin
		is_upper = (in_byte >= CHAR_UPPER_A) && (in_byte <= CHAR_UPPER_Z);
		is_lower = (in_byte >= CHAR_LOWER_A) && (in_byte <= CHAR_LOWER_Z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		byte_s1   <= in_byte;
		letter_s1 <= is_upper || is_lower;
		space_s1  <= (in_byte == CHAR_SPACE);
		dir_s1    <= dir_q;
		// lowering folds both cases onto one alphabet index
		if (is_upper)
			p_s1 <= LETTER_W'(in_byte - CHAR_UPPER_A);
		else
			p_s1 <= LETTER_W'(in_byte - CHAR_LOWER_A);
	end

	// stage 2: compare the letter against every key letter and key threshold
	logic [LETTER_W-1:0] enc_key;
	logic [LETTER_W-1:0] k_idx;
	logic [CNT_W-1:0]    cnt;
	logic                hit;
	logic [CNT_W-1:0]    hit_idx;
	logic [CNT_W-1:0]    less;
	logic                in_key;

	always_comb begin
		enc_key = '0;
		cnt     = '0;
		hit     = 1'b0;
		hit_idx = '0;
		less    = '0;
		// position among the letters that follow the key
		k_idx   = p_s1 - LETTER_W'(KEY_LEN_USED);
		in_key  = p_s1 < LETTER_W'(KEY_LEN_USED);
		for (int j = 0; j < KEY_LEN_USED; j++) begin
			if (p_s1 == LETTER_W'(j))
				enc_key = ki.letter[j];
			// k-th unused letter is k plus the sorted keys with thresh <= k
			if (ki.thresh[j] <= k_idx)
				cnt = cnt + CNT_W'(1);
			if (ki.letter[j] == p_s1) begin
				hit     = 1'b1;
				hit_idx = CNT_W'(j);
			end
			if (ki.letter[j] < p_s1)
				less = less + CNT_W'(1);
		end
	end

	logic                v_s2;
	logic [7:0]          byte_s2;
	logic [LETTER_W-1:0] p_s2;
	logic                letter_s2;
	logic                space_s2;
	logic                dir_s2;
	logic [LETTER_W-1:0] enc_key_s2;
	logic [LETTER_W-1:0] k_s2;
	logic [CNT_W-1:0]    cnt_s2;
	logic                hit_s2;
	logic [CNT_W-1:0]    hit_idx_s2;
	logic [CNT_W-1:0]    less_s2;
	logic                in_key_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		byte_s2    <= byte_s1;
		p_s2       <= p_s1;
		letter_s2  <= letter_s1;
		space_s2   <= space_s1;
		dir_s2     <= dir_s1;
		enc_key_s2 <= enc_key;
		k_s2       <= k_idx;
		cnt_s2     <= cnt;
		hit_s2     <= hit;
		hit_idx_s2 <= hit_idx;
		less_s2    <= less;
		in_key_s2  <= in_key;
	end

	// stage 3: final index and output byte select
	logic [LETTER_W-1:0] idx;
	logic [7:0]          res;

	always_comb begin
		if (dir_s2 == DIR_DECRYPT) begin
			// a key letter maps to its key slot, others follow the key in order
			if (hit_s2)
				idx = LETTER_W'(hit_idx_s2);
			else
				idx = LETTER_W'(KEY_LEN_USED) + p_s2 - LETTER_W'(less_s2);
		end else begin
			if (in_key_s2)
				idx = enc_key_s2;
			else
				idx = k_s2 + LETTER_W'(cnt_s2);
		end
		// bad key: pass through with no lowering or space mapping
		if (!ki.valid)
			res = byte_s2;
		else if (space_s2)
			res = SPACE_CODE;
		else if (letter_s2)
			res = CHAR_LOWER_A + {3'b000, idx};
		else
			res = byte_s2;
	end

	logic       done_s3;
	logic [7:0] out_byte_s3;
	logic       key_error_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s3 <= 1'b0;
		else
			done_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		out_byte_s3  <= res;
		key_error_s3 <= !ki.valid;
	end

	assign done      = done_s3;
	assign out_byte  = out_byte_s3;
	assign key_error = key_error_s3;

	// every result comes from a request taken earlier with start high
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result without a request");

	// a bad key passes the byte through untouched
	a_bad_key_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && key_error) |-> (out_byte == $past(in_byte, 3)))
		else $error("byte changed under a bad key");

	// a space maps to the space code under a good key
	a_space_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !key_error && ($past(in_byte, 3) == CHAR_SPACE)) |->
		(out_byte == SPACE_CODE))
		else $error("space not mapped");

endmodule

`default_nettype wire

[dv/keyword_substitution_cipher_checker.sv]
`timescale 1ns / 1ps

module keyword_substitution_cipher_checker #(
	parameter int KEY_LENGTH = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [7:0]                       in_byte,
	input  logic                             done,
	input  logic [7:0]                       out_byte,
	input  logic                             key_error,
	input  logic                             cfg_we,
	input  logic [ksc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ksc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               mismatches,
	output int                               cipher_pending,
	output int                               bytes_checked,
	output int                               key_error_bytes
);
	import ksc_pkg::*;

	localparam int KEY_USED = (KEY_LENGTH > NUM_KEY_REGS) ? NUM_KEY_REGS : KEY_LENGTH;

	typedef struct packed {
		logic [7:0] text;
		logic       key_error;
	} cipher_byte_t;

	cipher_byte_t cipher_q[$];
	key_set_t     key_copy;
	logic         dir_copy;

	// expected output for one byte under the given key and direction
	function automatic cipher_byte_t substitute(input logic [7:0] b, input key_set_t key,
			input logic dir);
		logic [ALPHA_SIZE-1:0] taken;
		logic [LETTER_W-1:0]   alphabet [ALPHA_SIZE];
		logic [LETTER_W-1:0]   v;
		logic [7:0]            c;
		int                    pos;
		int                    i;
		bit                    bad;
		cipher_byte_t          r;
		taken = '0;
		pos = 0;
		bad = 1'b0;
		r.text = b;
		r.key_error = 1'b0;
		for (i = 0; i < KEY_USED; i++) begin
			v = key[i];
			if (v >= ALPHA_SIZE || taken[v]) begin
				bad = 1'b1;
				break;
			end
			taken[v] = 1'b1;
			alphabet[pos] = v;
			pos++;
		end
		if (bad) begin
			r.key_error = 1'b1;
			return r;
		end
		for (i = 0; i < ALPHA_SIZE; i++) begin
			if (!taken[i]) begin
				alphabet[pos] = LETTER_W'(i);
				pos++;
			end
		end
		c = b;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
			c = c + (CHAR_LOWER_A - CHAR_UPPER_A);
		if (c == CHAR_SPACE) begin
			r.text = SPACE_CODE;
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			if (dir == DIR_ENCRYPT) begin
				r.text = CHAR_LOWER_A + 8'(alphabet[c - CHAR_LOWER_A]);
			end else begin
				for (i = 0; i < ALPHA_SIZE; i++) begin
					if (alphabet[i] == LETTER_W'(c - CHAR_LOWER_A)) begin
						r.text = CHAR_LOWER_A + 8'(i);
						break;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: mismatch on %s: got 0x%02h, wanted 0x%02h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cipher_byte_t want;
		int           k;
		if (!arst_n) begin
			cipher_q.delete();
			for (k = 0; k < NUM_KEY_REGS; k++)
				key_copy[k] = LETTER_W'(k);
			dir_copy = DIR_ENCRYPT;
			mismatches = 0;
			bytes_checked = 0;
			key_error_bytes = 0;
			cipher_pending <= 0;
		end else begin
			if (done) begin
				if (cipher_q.size() == 0) begin
					report_mismatch("result with no request outstanding", out_byte, 8'h00);
				end else begin
					want = cipher_q.pop_front();
					bytes_checked++;
					if (key_error === 1'b1)
						key_error_bytes++;
					if (out_byte !== want.text)
						report_mismatch("out_byte", out_byte, want.text);
					if (key_error !== want.key_error)
						report_mismatch("key_error", 8'(key_error), 8'(want.key_error));
				end
			end
			if (start && !busy)
				cipher_q.push_back(substitute(in_byte, key_copy, dir_copy));
			if (cfg_we) begin
				if (int'(cfg_index) < NUM_KEY_REGS)
					key_copy[cfg_index] = cfg_data;
				else if (cfg_index == REG_DIRECTION)
					dir_copy = cfg_data[0];
			end
			cipher_pending <= cipher_q.size();
		end
	end

endmodule

[dv/keyword_substitution_cipher_tb.sv]
`timescale 1ns / 1ps

module keyword_substitution_cipher_tb;
	import ksc_pkg::*;

	localparam int KEY_LENGTH    = 5;
	localparam int SETTLE_CYCLES = 8;       // pipeline is three deep, plus margin
	localparam int CYCLE_LIMIT   = 200000;  // far above the slowest correct run
	localparam int RANDOM_BYTES  = 450;

	// indexes above the direction register, which the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_DIRECTION + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_DIRECTION + 3'd2;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [7:0]            in_byte = 8'h00;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  done;
	logic [7:0]            out_byte;
	logic                  key_error;

	int mismatches;
	int cipher_pending;
	int bytes_checked;
	int key_error_bytes;
	int cycle_count = 0;
	int bytes_sent = 0;
	int key_settings = 0;

	// sender pacing state
	bit start_raised = 1'b0;
	int burst_left = 0;
	bit no_idle = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	keyword_substitution_cipher #(
		.KEY_LENGTH(KEY_LENGTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_byte   (in_byte),
		.done      (done),
		.out_byte  (out_byte),
		.key_error (key_error),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	keyword_substitution_cipher_checker #(
		.KEY_LENGTH(KEY_LENGTH)
	) u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.in_byte         (in_byte),
		.done            (done),
		.out_byte        (out_byte),
		.key_error       (key_error),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.cipher_pending  (cipher_pending),
		.bytes_checked   (bytes_checked),
		.key_error_bytes (key_error_bytes)
	);

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				cipher_pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// one request; start stays high so the next call can follow back to back
	task automatic send_byte(input logic [7:0] b);
		start <= 1'b1;
		in_byte <= b;
		start_raised = 1'b1;
		do @(posedge clk); while (busy);
		bytes_sent++;
	endtask

	// lower start only if it is up, so no step sees two assignments to it
	task automatic lower_start;
		if (start_raised) begin
			start <= 1'b0;
			start_raised = 1'b0;
		end
	endtask

	// bursts of random length, random gaps between them unless idling is off
	task automatic pace;
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!no_idle) begin
				gap = $urandom_range(1, 6);
				lower_start();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every request has come back, then let the pipe empty
	task automatic drain;
		lower_start();
		do @(posedge clk); while (cipher_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// cfg_we stays high across consecutive writes; close_writes drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// the key summary is registered from the key registers, give it time
	task automatic close_writes;
		cfg_we <= 1'b0;
		key_settings++;
		repeat (4) @(posedge clk);
	endtask

	task automatic load_key(input key_set_t k, input logic [CFG_DATA_W-1:0] dir_word);
		int i;
		for (i = 0; i < NUM_KEY_REGS; i++)
			write_reg(REG_KEY_LETTER_0 + CFG_IDX_W'(i), k[i]);
		write_reg(REG_DIRECTION, dir_word);
	endtask

	// mostly letters of either case, some spaces, the rest any byte at all
	function automatic logic [7:0] pick_text;
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return CHAR_LOWER_A + 8'($urandom_range(0, 25));
		if (r < 65)
			return CHAR_UPPER_A + 8'($urandom_range(0, 25));
		if (r < 75)
			return CHAR_SPACE;
		return 8'($urandom_range(0, 255));
	endfunction

	// distinct letters most of the time; sometimes a repeat or a letter past z
	function automatic key_set_t pick_key;
		key_set_t              k;
		logic [ALPHA_SIZE-1:0] taken;
		int                    j;
		int                    v;
		int                    r;
		int                    a;
		taken = '0;
		for (j = 0; j < NUM_KEY_REGS; j++) begin
			do v = $urandom_range(0, ALPHA_SIZE - 1); while (taken[v]);
			taken[v] = 1'b1;
			k[j] = LETTER_W'(v);
		end
		r = $urandom_range(0, 99);
		if (r < 12) begin
			a = $urandom_range(0, NUM_KEY_REGS - 1);
			k[(a + $urandom_range(1, NUM_KEY_REGS - 1)) % NUM_KEY_REGS] = k[a];
		end else if (r < 22) begin
			k[$urandom_range(0, NUM_KEY_REGS - 1)] = LETTER_W'($urandom_range(ALPHA_SIZE, 31));
		end
		return k;
	endfunction

	initial begin
		logic [7:0] boundary_bytes [12];
		key_set_t   k;
		int         phase_len;
		int         random_sent;
		int         i;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key a..e, encrypt: letter range ends, both cases, space, neighbors
		// of each letter range, the extreme bytes and a byte equal to the space code
		boundary_bytes = '{CHAR_LOWER_A, CHAR_LOWER_Z, CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_SPACE,
			CHAR_UPPER_A - 8'd1, CHAR_UPPER_Z + 8'd1, CHAR_LOWER_A - 8'd1,
			CHAR_LOWER_Z + 8'd1, 8'h00, 8'hFF, SPACE_CODE};
		foreach (boundary_bytes[n])
			send_byte(boundary_bytes[n]);
		drain();

		// a real keyword in decrypt mode; the spare indexes get 1f and 1e, the latter
		// of which would flip the direction if the spare indexes were decoded
		k[0] = 5'd16;
		k[1] = 5'd20;
		k[2] = 5'd8;
		k[3] = 5'd2;
		k[4] = 5'd10;
		load_key(k, CFG_DATA_W'(DIR_DECRYPT));
		write_reg(REG_SPARE_LO, 5'h1F);
		write_reg(REG_SPARE_HI, 5'h1E);
		close_writes();
		send_byte(CHAR_LOWER_A + 8'd16);
		send_byte(CHAR_LOWER_Z);
		send_byte(CHAR_UPPER_A + 8'd4);
		send_byte(CHAR_SPACE);
		drain();

		// repeated key letter: bytes pass through raw, no lowering, no space code
		k[0] = 5'd0;
		k[1] = 5'd1;
		k[2] = 5'd0;
		k[3] = 5'd3;
		k[4] = 5'd4;
		load_key(k, CFG_DATA_W'(DIR_ENCRYPT));
		close_writes();
		send_byte(CHAR_LOWER_A);
		send_byte(CHAR_SPACE);
		send_byte(CHAR_UPPER_A + 8'd16);
		drain();

		// key letter past z counts as an invalid key too
		k[2] = 5'd2;
		k[4] = 5'd31;
		write_reg(REG_KEY_LETTER_0 + CFG_IDX_W'(2), k[2]);
		write_reg(REG_KEY_LETTER_0 + CFG_IDX_W'(4), k[4]);
		close_writes();
		send_byte(CHAR_LOWER_A + 8'd1);
		send_byte(CHAR_UPPER_A + 8'd1);
		drain();

		// extreme letters z and a inside a valid key, encrypt
		k[0] = 5'd25;
		k[1] = 5'd0;
		k[2] = 5'd12;
		k[3] = 5'd13;
		k[4] = 5'd1;
		load_key(k, CFG_DATA_W'(DIR_ENCRYPT));
		close_writes();
		send_byte(CHAR_LOWER_A);
		send_byte(CHAR_LOWER_A + 8'd24);
		send_byte(CHAR_UPPER_Z);
		drain();

		// random phases: new key and direction while idle, then a paced stream
		random_sent = 0;
		while (random_sent < RANDOM_BYTES) begin
			k = pick_key();
			for (i = 0; i < NUM_KEY_REGS; i++) begin
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_KEY_LETTER_0 + CFG_IDX_W'(i), k[i]);
			end
			write_reg(REG_DIRECTION, CFG_DATA_W'($urandom_range(0, 31)));
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
					CFG_DATA_W'($urandom_range(0, 31)));
			close_writes();

			no_idle = ($urandom_range(0, 3) == 0);
			burst_left = 0;
			phase_len = $urandom_range(20, 60);
			// the last phase stops at the byte budget
			if (phase_len > RANDOM_BYTES - random_sent)
				phase_len = RANDOM_BYTES - random_sent;
			repeat (phase_len) begin
				send_byte(pick_text());
				pace();
			end
			random_sent += phase_len;
			drain();
		end

		$display("sent %0d bytes under %0d key settings", bytes_sent, key_settings);
		$display("checked %0d results, %0d of them flagged with a key error", bytes_checked,
			key_error_bytes);
		if (mismatches == 0 && cipher_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ksc_pkg.sv
hw/rtl/ksc_keymap.sv
hw/rtl/keyword_substitution_cipher.sv
dv/keyword_substitution_cipher_checker.sv
dv/keyword_substitution_cipher_tb.sv
